/* rtl/tpt_pkg.sv */
// ----------------------------------------------------------------------------
// Task power tracker package
// Shared types and constants of the task power tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package tpt_pkg;
  localparam int unsigned TasksDefault = 16;
  localparam int unsigned SlotW = 4;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [16:0] GainReset = 17'd6554;
  localparam logic [16:0] GainMax = 17'h1_0000;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_BASE = 1'd0,
    CFG_GAIN = 1'd1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_SUB,
    ST_MUL,
    ST_STORE,
    ST_SCAN,
    ST_SCORE_RD,
    ST_SCORE,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

/* rtl/tpt_divider.sv */
// ----------------------------------------------------------------------------
// Task power tracker divider
// Restoring bit-serial divider, one quotient bit per cycle, 65-bit remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module tpt_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [79:0] num_i,
  input  wire logic [63:0] den_i,
  input  wire logic [6:0]  bits_i,
  output logic             done_o,
  output logic [79:0]      quo_o
);
  logic [79:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [64:0] shifted;
  logic [65:0] diff;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    run_d = run_q;
    shifted = {rem_q[63:0], quo_q[79]};
    diff = {1'b0, shifted} - {2'b0, den_q};
    done_o = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = bits_i;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = diff[65] ? shifted : diff[64:0];
      quo_d = {quo_q[78:0], ~diff[65]};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d = 1'b0;
      end
    end else begin
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

/* rtl/tpt_multiplier.sv */
// ----------------------------------------------------------------------------
// Task power tracker multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, 17 by 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tpt_multiplier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [48:0]      prod_o
);
  logic [48:0] acc_q, acc_d;
  logic [48:0] b_q, b_d;
  logic [16:0] a_q, a_d;
  logic [4:0]  cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    b_d = b_q;
    a_d = a_q;
    cnt_d = cnt_q;
    done_o = (cnt_q == 5'd0);
    if (start_i) begin
      acc_d = '0;
      b_d = {17'd0, b_i};
      a_d = a_i;
      cnt_d = 5'd17;
    end else if (cnt_q != 5'd0) begin
      if (a_q[0]) begin
        acc_d = acc_q + b_q;
      end
      b_d = {b_q[47:0], 1'b0};
      a_d = {1'b0, a_q[16:1]};
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q <= b_d;
    a_q <= a_d;
  end

  assign prod_o = acc_q;
endmodule
`default_nettype wire

/* rtl/task_power_tracker_unit.sv */
// ----------------------------------------------------------------------------
// Task power tracker
// Per-slot power estimates with least power and score per item.
// ----------------------------------------------------------------------------
// One item is handled at a time. An add, a query or an item that needs no
// score divide passes through read, check, score read and output before the
// next beat is accepted. A remove that drops an estimate adds a scan of all
// TASKS slots. An update that forms a power adds a serial divide and base
// subtraction, two serial 17-bit multiplies when the slot already holds an
// estimate, a store step and the scan. Every item with a valid estimate and
// nonzero least power adds a serial score divide. The serial divider and
// multiplier and the one-entry-per-cycle scan set the rate. Slot memories are
// cleared by valid bits at reset.
`default_nettype none
module task_power_tracker_unit #(
  parameter int unsigned TASKS = tpt_pkg::TasksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  task_slot_i,
  input  wire logic [63:0] energy_count_i,
  input  wire logic [63:0] busy_time_i,
  input  wire logic [63:0] sample_stamp_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      score_o,
  output logic             has_power_o,
  output logic [31:0]      min_power_o
);
  import tpt_pkg::*;

  localparam int unsigned IdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CntW = $clog2(TASKS + 1);

  logic [31:0] base_q;
  logic [16:0] gain_q;

  logic [TASKS-1:0] present_q, pvalid_q;
  logic [63:0] energy_mem [TASKS];
  logic [63:0] busy_mem [TASKS];
  logic [63:0] stamp_mem [TASKS];
  logic [31:0] power_mem [TASKS];

  state_e state_q, state_d;
  kind_e kind_q;
  logic [3:0]  slot_q;
  logic [IdxW-1:0] idx;
  logic in_range;
  logic [63:0] e_q, b_q, t_q;
  logic [63:0] le_q, lb_q, ls_q;
  logic [31:0] pw_q, p_q, mix_q;
  logic [48:0] acc_q;
  logic        second_q;
  logic [31:0] least_q, most_q, lo_q, hi_q;
  logic        any_q;
  logic [CntW-1:0] scan_q;
  logic [31:0] scan_val_q;
  logic        scan_vld_q;
  logic        scan_rd_q;
  logic [31:0] score_q;
  logic        has_q;

  logic        div_start, div_done, mul_start, mul_done;
  logic [79:0] div_num, div_quo;
  logic [63:0] div_den;
  logic [6:0]  div_bits;
  logic [16:0] mul_a;
  logic [31:0] mul_b;
  logic [48:0] mul_prod;
  logic [63:0] de, dt;
  logic [16:0] gsat;
  logic [31:0] quo_sat;

  assign idx = IdxW'(slot_q);
  assign in_range = ({28'd0, slot_q} < 32'(TASKS));
  assign de = e_q - le_q;
  assign dt = b_q - lb_q;
  assign gsat = (gain_q > GainMax) ? GainMax : gain_q;
  assign quo_sat = (div_quo[79:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];

  tpt_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .bits_i(div_bits), .done_o(div_done), .quo_o(div_quo)
  );

  tpt_multiplier u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    div_num = {de, 16'd0};
    div_den = dt;
    div_bits = 7'd80;
    mul_start = 1'b0;
    mul_a = second_q ? gsat : (GainMax - gsat);
    mul_b = second_q ? p_q : pw_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!in_range) begin
          state_d = ST_SCORE;
        end else if (kind_q == KIND_UPDATE) begin
          if (present_q[idx] && (t_q > ls_q) && (de != '0) && (dt != '0)) begin
            div_start = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_SCORE_RD;
          end
        end else if (kind_q == KIND_REMOVE && pvalid_q[idx]) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_SCORE_RD;
        end
      end
      ST_DIV: if (div_done) state_d = ST_SUB;
      ST_SUB: begin
        if (pvalid_q[idx]) begin
          mul_start = 1'b1;
          mul_a = GainMax - gsat;
          mul_b = pw_q;
          state_d = ST_MUL;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (!second_q) begin
            mul_start = 1'b1;
            mul_a = gsat;
            mul_b = p_q;
          end else begin
            state_d = ST_STORE;
          end
        end
      end
      ST_STORE: state_d = ST_SCAN;
      ST_SCAN: if (scan_q == CntW'(TASKS) && !scan_rd_q) state_d = ST_SCORE_RD;
      ST_SCORE_RD: begin
        if (pvalid_q[idx] && least_q != '0) begin
          div_start = 1'b1;
          div_num = {pw_q, 48'd0};
          div_den = {32'd0, least_q};
          div_bits = 7'd48;
          state_d = ST_SCORE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SCORE: begin
        if (!in_range) state_d = ST_OUT;
        else if (div_done) state_d = ST_OUT;
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q <= '0;
      gain_q <= GainReset;
      present_q <= '0;
      pvalid_q <= '0;
      least_q <= '0;
      most_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      second_q <= 1'b0;
      scan_q <= '0;
      scan_rd_q <= 1'b0;
      any_q <= 1'b0;
      kind_q <= KIND_QUERY;
      slot_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_BASE: base_q <= cfg_data_i;
          CFG_GAIN: gain_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_valid_i) begin
        kind_q <= kind_e'(kind_i);
        slot_q <= task_slot_i;
      end
      if (state_q == ST_CHECK && in_range) begin
        if (kind_q == KIND_ADD) begin
          present_q[idx] <= 1'b1;
        end else if (kind_q == KIND_REMOVE) begin
          present_q[idx] <= 1'b0;
          pvalid_q[idx] <= 1'b0;
        end
      end
      if (state_q == ST_SUB) second_q <= 1'b0;
      if (state_q == ST_MUL && mul_done) second_q <= 1'b1;
      if (state_q == ST_STORE) pvalid_q[idx] <= 1'b1;
      if (state_d == ST_SCAN && state_q != ST_SCAN) begin
        scan_q <= '0;
        scan_rd_q <= 1'b0;
        any_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        scan_rd_q <= (scan_q != CntW'(TASKS));
        if (scan_q != CntW'(TASKS)) scan_q <= scan_q + CntW'(1);
        if (scan_rd_q && scan_vld_q) begin
          any_q <= 1'b1;
          if (!any_q || scan_val_q < lo_q) lo_q <= scan_val_q;
          if (!any_q || scan_val_q > hi_q) hi_q <= scan_val_q;
        end
        if (scan_q == CntW'(TASKS) && !scan_rd_q) begin
          least_q <= any_q ? lo_q : '0;
          most_q <= any_q ? hi_q : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      e_q <= energy_count_i;
      b_q <= busy_time_i;
      t_q <= sample_stamp_i;
    end
    if (state_q == ST_READ) begin
      le_q <= energy_mem[idx];
      lb_q <= busy_mem[idx];
      ls_q <= stamp_mem[idx];
      pw_q <= power_mem[idx];
    end
    if (state_q == ST_STORE) begin
      pw_q <= second_q ? mix_q : p_q;
    end
    if (state_q == ST_CHECK && in_range) begin
      if (kind_q == KIND_ADD || kind_q == KIND_REMOVE) begin
        energy_mem[idx] <= '0;
        busy_mem[idx] <= '0;
        stamp_mem[idx] <= '0;
        if (kind_q == KIND_REMOVE) power_mem[idx] <= '0;
      end else if (kind_q == KIND_UPDATE && present_q[idx] && (t_q > ls_q)) begin
        energy_mem[idx] <= e_q;
        busy_mem[idx] <= b_q;
        stamp_mem[idx] <= t_q;
      end
    end
    if (state_q == ST_SUB) begin
      if (quo_sat > base_q) begin
        p_q <= quo_sat - base_q;
      end else begin
        p_q <= '0;
      end
    end
    if (state_q == ST_MUL && mul_done && !second_q) acc_q <= mul_prod;
    if (state_q == ST_MUL && mul_done && second_q) begin
      mix_q <= 32'((acc_q + mul_prod) >> 16);
    end
    if (state_q == ST_STORE) begin
      power_mem[idx] <= second_q ? mix_q : p_q;
    end
    if (state_q == ST_SCAN && scan_q != CntW'(TASKS)) begin
      scan_val_q <= power_mem[scan_q[IdxW-1:0]];
      scan_vld_q <= pvalid_q[scan_q[IdxW-1:0]];
    end
    if (state_q == ST_SCORE_RD) begin
      has_q <= pvalid_q[idx];
      score_q <= OneQ16;
    end
    if (state_q == ST_SCORE) begin
      if (!in_range) begin
        has_q <= 1'b0;
        score_q <= OneQ16;
      end else if (div_done) begin
        score_q <= (div_quo[47:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign score_o = score_q;
  assign has_power_o = has_q;
  assign min_power_o = least_q;
endmodule
`default_nettype wire

/* verif/task_power_tracker_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Task power tracker checker
// Watches the configuration port and both channels of the task power tracker.
// It keeps its own copy of the slot table and computes each slot's score.
// Every result beat is compared field by field with the oldest expected
// result.
// ----------------------------------------------------------------------------
module task_power_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  task_slot_i,
  input  logic [63:0] energy_count_i,
  input  logic [63:0] busy_time_i,
  input  logic [63:0] sample_stamp_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] score_i,
  input  logic        has_power_i,
  input  logic [31:0] min_power_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import tpt_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [31:0] score;
    logic        has_power;
    logic [31:0] min_power;
  } score_t;

  logic [31:0] idle_power;
  logic [16:0] gain;
  logic        present [NumSlots];
  logic [63:0] energy_seen [NumSlots];
  logic [63:0] busy_seen [NumSlots];
  logic [63:0] stamp_seen [NumSlots];
  logic        estimated [NumSlots];
  logic [31:0] estimate [NumSlots];
  logic [31:0] least;
  score_t      want_buf [QueueDepth];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  int unsigned fill;

  assign pending_o = fill;

  function automatic void find_least();
    logic any;
    any = 1'b0;
    least = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (estimated[i] && (!any || estimate[i] < least)) begin
        least = estimate[i];
      end
      if (estimated[i]) begin
        any = 1'b1;
      end
    end
  endfunction

  function automatic logic [31:0] sample_power(logic [63:0] de, logic [63:0] dt);
    logic [127:0] q;
    q = {48'd0, de, 16'd0} / {64'd0, dt};
    if (q > 128'hFFFF_FFFF) begin
      q = 128'hFFFF_FFFF;
    end
    return (q[31:0] > idle_power) ? q[31:0] - idle_power : 32'd0;
  endfunction

  function automatic void take_sample(int s, logic [63:0] e, logic [63:0] b,
                                      logic [63:0] t);
    logic [63:0] de;
    logic [63:0] dt;
    logic [31:0] p;
    logic [63:0] g;
    logic [63:0] mix;
    if (!present[s] || !(t > stamp_seen[s])) begin
      return;
    end
    de = e - energy_seen[s];
    dt = b - busy_seen[s];
    energy_seen[s] = e;
    busy_seen[s] = b;
    stamp_seen[s] = t;
    if (de == 0 || dt == 0) begin
      return;
    end
    p = sample_power(de, dt);
    if (!estimated[s]) begin
      estimate[s] = p;
      estimated[s] = 1'b1;
    end else begin
      g = (gain > GainMax) ? 64'(GainMax) : 64'(gain);
      mix = (64'h1_0000 - g) * 64'(estimate[s]) + g * 64'(p);
      estimate[s] = mix[47:16];
    end
    find_least();
  endfunction

  function automatic score_t predict_score(kind_e kind, int s, logic [63:0] e,
                                           logic [63:0] b, logic [63:0] t);
    score_t r;
    logic [47:0] q;
    case (kind)
      KIND_ADD: begin
        present[s] = 1'b1;
        energy_seen[s] = '0;
        busy_seen[s] = '0;
        stamp_seen[s] = '0;
      end
      KIND_REMOVE: begin
        present[s] = 1'b0;
        energy_seen[s] = '0;
        busy_seen[s] = '0;
        stamp_seen[s] = '0;
        if (estimated[s]) begin
          estimated[s] = 1'b0;
          estimate[s] = '0;
          find_least();
        end
      end
      KIND_UPDATE: take_sample(s, e, b, t);
      default: ;
    endcase
    r.score = OneQ16;
    r.has_power = estimated[s];
    if (estimated[s] && least != 0) begin
      q = {estimate[s], 16'd0} / {16'd0, least};
      r.score = (q > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    r.min_power = least;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_t got;
    score_t want;
    logic   popped;
    logic   pushed;
    popped = 1'b0;
    pushed = 1'b0;
    if (!rst_ni) begin
      idle_power <= '0;
      gain <= GainReset;
      for (int i = 0; i < NumSlots; i++) begin
        present[i] = 1'b0;
        energy_seen[i] = '0;
        busy_seen[i] = '0;
        stamp_seen[i] = '0;
        estimated[i] = 1'b0;
        estimate[i] = '0;
      end
      least = '0;
      fail_count_o <= 0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_e'(cfg_index_i) == CFG_BASE) begin
          idle_power <= cfg_data_i;
        end else begin
          gain <= cfg_data_i[16:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{score_i, has_power_i, min_power_i};
        if (fill == 0) begin
          $error("result beat with no expected result");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = want_buf[rd_ptr];
          popped = 1'b1;
          rd_ptr <= rd_ptr + 2'd1;
          if (got.score !== want.score) begin
            $error("score: expected %h, got %h", want.score, got.score);
          end
          if (got.has_power !== want.has_power) begin
            $error("has_power: expected %b, got %b", want.has_power, got.has_power);
          end
          if (got.min_power !== want.min_power) begin
            $error("min_power: expected %h, got %h", want.min_power, got.min_power);
          end
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (fill >= QueueDepth) begin
          $error("more input beats in flight than the checker holds");
        end
        want_buf[wr_ptr] = predict_score(kind_e'(kind_i), int'(task_slot_i),
                                         energy_count_i, busy_time_i,
                                         sample_stamp_i);
        pushed = 1'b1;
        wr_ptr <= wr_ptr + 2'd1;
      end
      fill <= fill + (pushed ? 1 : 0) - (popped ? 1 : 0);
    end
  end
endmodule

/* verif/task_power_tracker_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Task power tracker testbench
// Drives a directed list of items and then phases of mostly well-formed
// random sample streams under different idle and stall patterns. The
// register settings change between phases. The checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module task_power_tracker_unit_tb;
  import tpt_pkg::*;

  localparam int unsigned PhaseItems = 250;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned StallLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [3:0]  task_slot_i;
  logic [63:0] energy_count_i;
  logic [63:0] busy_time_i;
  logic [63:0] sample_stamp_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] score_o;
  logic        has_power_o;
  logic [31:0] min_power_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned beats_sent;
  logic [63:0] slot_energy [16];
  logic [63:0] slot_busy [16];
  logic [63:0] slot_stamp [16];

  task_power_tracker_unit DUT (.*);

  task_power_tracker_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .task_slot_i,
    .energy_count_i, .busy_time_i, .sample_stamp_i,
    .out_valid_i(out_valid_o), .out_ready_i, .score_i(score_o),
    .has_power_i(has_power_o), .min_power_i(min_power_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_e index, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic issue(kind_e kind, logic [3:0] slot, logic [63:0] e, logic [63:0] b,
                       logic [63:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    task_slot_i <= slot;
    energy_count_i <= e;
    busy_time_i <= b;
    sample_stamp_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (kind == KIND_ADD || kind == KIND_REMOVE) begin
      slot_energy[slot] = '0;
      slot_busy[slot] = '0;
      slot_stamp[slot] = '0;
    end else if (kind == KIND_UPDATE && t > slot_stamp[slot]) begin
      slot_energy[slot] = e;
      slot_busy[slot] = b;
      slot_stamp[slot] = t;
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_item();
    logic [3:0]  slot;
    logic [63:0] de;
    logic [63:0] dt;
    int unsigned pick;
    int unsigned shape;
    slot = 4'($urandom_range(15));
    pick = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < 8) begin
      issue(kind_e'($urandom_range(3)), 4'($urandom), {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom, $urandom});
    end else if (pick < 20) begin
      issue(KIND_ADD, slot, {$urandom, $urandom}, {$urandom, $urandom}, '0);
    end else if (pick < 26) begin
      issue(KIND_REMOVE, slot, '0, '0, '0);
    end else if (pick < 36) begin
      issue(KIND_QUERY, slot, '0, '0, '0);
    end else begin
      de = 64'($urandom_range(1, 5000));
      dt = 64'($urandom_range(1, 5000));
      if (shape < 5) begin
        de = '0;
      end else if (shape < 10) begin
        dt = '0;
      end else if (shape < 20) begin
        de = {$urandom, $urandom};
        dt = {$urandom, $urandom};
      end
      issue(KIND_UPDATE, slot, slot_energy[slot] + de, slot_busy[slot] + dt,
            (shape >= 95) ? slot_stamp[slot] : slot_stamp[slot] + $urandom_range(1, 1000));
    end
  endtask

  initial begin
    logic [31:0] base_set [5];
    logic [31:0] gain_set [5];
    int unsigned idle_set [5];
    int unsigned stall_set [5];
    base_set = '{32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0000, 32'h0000_0100};
    gain_set = '{32'h0_0000, 32'h1_0000, 32'h1_FFFF, 32'h0_8000, 32'h0_199A};
    idle_set = '{0, 85, 0, 19, 0};
    stall_set = '{0, 0, 85, 19, 0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = '0;
    task_slot_i = '0;
    energy_count_i = '0;
    busy_time_i = '0;
    sample_stamp_i = '0;
    out_ready_i = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    beats_sent = 0;
    for (int i = 0; i < 16; i++) begin
      slot_energy[i] = '0;
      slot_busy[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(KIND_QUERY, 4'd0, '0, '0, '0);
    issue(KIND_UPDATE, 4'd3, 64'd500, 64'd50, 64'd9);
    issue(KIND_ADD, 4'd0, '0, '0, '0);
    issue(KIND_UPDATE, 4'd0, 64'd1000, 64'd100, 64'd5);
    issue(KIND_UPDATE, 4'd0, 64'd3000, 64'd150, 64'd5);
    issue(KIND_UPDATE, 4'd0, 64'd1000, 64'd110, 64'd6);
    issue(KIND_ADD, 4'd1, '0, '0, '0);
    issue(KIND_UPDATE, 4'd1, '1, 64'd1, 64'd1);
    issue(KIND_QUERY, 4'd0, '0, '0, '0);
    issue(KIND_REMOVE, 4'd1, '0, '0, '0);
    issue(KIND_ADD, 4'd1, '0, '0, '0);
    issue(KIND_UPDATE, 4'd1, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FF00, 64'd10);
    issue(KIND_UPDATE, 4'd1, 64'h10, 64'h20, 64'd11);
    issue(KIND_ADD, 4'd15, '0, '0, '0);
    issue(KIND_UPDATE, 4'd15, 64'd1, '1, '1);
    issue(KIND_UPDATE, 4'd15, 64'd5, 64'd0, '1);
    issue(KIND_QUERY, 4'd15, '0, '0, '0);
    issue(KIND_REMOVE, 4'd7, '0, '0, '0);
    issue(KIND_UPDATE, 4'd0, 64'd2000, 64'd200, 64'd7);
    issue(KIND_QUERY, 4'd1, '0, '0, '0);
    issue(KIND_REMOVE, 4'd0, '0, '0, '0);
    issue(KIND_REMOVE, 4'd1, '0, '0, '0);
    issue(KIND_REMOVE, 4'd15, '0, '0, '0);
    issue(KIND_QUERY, 4'd0, '0, '0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(CFG_BASE, base_set[ph]);
      write_reg(CFG_GAIN, gain_set[ph]);
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        random_item();
      end
    end

    recv_stall_pct = 0;
    settle();
    $display("Sent %0d item beats over five register settings and idle patterns,",
             beats_sent);
    $display("covering add, remove, update and query on all sixteen slots.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
